@@ design/rmt_pkg.sv @@
// rmt_pkg: shared types, codes and the checksum helper of the message tracker
// no dependencies

package rmt_pkg;

	localparam int unsigned SEND_SLOTS_DEF    = 8;
	localparam int unsigned HISTORY_DEPTH_DEF = 16;
	localparam logic [7:0]  RETRY_LIMIT_RST   = 8'd10;
	localparam logic [16:0] ADLER_MOD         = 17'd65521;

	typedef enum logic [1:0] {
		CMD_SEND    = 2'd0,
		CMD_RECV    = 2'd1,
		CMD_CONFIRM = 2'd2,
		CMD_TICK    = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		K_SENT      = 4'd0,
		K_ACCEPTED  = 4'd1,
		K_CHKERR    = 4'd2,
		K_DUPLICATE = 4'd3,
		K_MALFORMED = 4'd4,
		K_CONFIRMED = 4'd5,
		K_UNMATCHED = 4'd6,
		K_RESEND    = 4'd7,
		K_LOST      = 4'd8
	} kind_t;

	typedef struct packed {
		logic  load;
		logic  sum_upd;
		logic  idx_clr;
		logic  idx_inc;
		logic  use_pick;
		logic  send_scan;
		logic  send_commit;
		logic  recv_scan;
		logic  recv_commit;
		logic  conf_scan;
		logic  conf_commit;
		logic  time_inc;
		logic  tick_scan;
		logic  emit;
		kind_t emit_kind;
	} dp_cmd_t;

	typedef struct packed {
		op_t  op;
		logic last;
		logic nopay;
		logic chk_ok;
		logic hit;
		logic slot_end;
		logic hist_end;
		logic flag_here;
		logic lost_here;
		logic out_free;
	} dp_stat_t;

	function automatic logic [15:0] sum_add(input logic [15:0] s, input logic [7:0] b);
		logic [16:0] t;
		t = {1'b0, s} + {9'd0, b};
		if (t >= ADLER_MOD)
			t = t - ADLER_MOD;
		return t[15:0];
	endfunction

endpackage

@@ design/rmt_ctrl.sv @@
// rmt_ctrl: sequencing state machine of the message tracker
// depends on rmt_pkg; drives the datapath rmt_dp through dp_cmd_t

module rmt_ctrl import rmt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_SEND_SCAN, S_SEND_COMMIT, S_RECV_SCAN, S_RECV_COMMIT,
		S_CONF_SCAN, S_CONF_COMMIT, S_TICK_SCAN, S_TICK_EMIT, S_EMIT
	} state_t;

	state_t state_q, state_n;
	kind_t  kind_q, kind_n;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.emit_kind = kind_q;
		state_n = state_q;
		kind_n = kind_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_n = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.idx_clr = 1'b1;
				case (stat.op)
					CMD_SEND: begin
						cmd.sum_upd = 1'b1;
						state_n = stat.last ? S_SEND_SCAN : S_IDLE;
					end
					CMD_RECV: begin
						cmd.sum_upd = 1'b1;
						if (stat.nopay) begin
							kind_n = K_MALFORMED;
							state_n = S_EMIT;
						end else if (!stat.last) begin
							state_n = S_IDLE;
						end else if (!stat.chk_ok) begin
							kind_n = K_CHKERR;
							state_n = S_EMIT;
						end else begin
							state_n = S_RECV_SCAN;
						end
					end
					CMD_CONFIRM: state_n = S_CONF_SCAN;
					default: begin
						cmd.time_inc = 1'b1;
						state_n = S_TICK_SCAN;
					end
				endcase
			end
			S_SEND_SCAN: begin
				cmd.send_scan = 1'b1;
				cmd.idx_inc = 1'b1;
				if (stat.slot_end)
					state_n = S_SEND_COMMIT;
			end
			S_SEND_COMMIT: begin
				cmd.use_pick = 1'b1;
				cmd.send_commit = 1'b1;
				kind_n = K_SENT;
				state_n = S_EMIT;
			end
			S_RECV_SCAN: begin
				cmd.recv_scan = 1'b1;
				cmd.idx_inc = 1'b1;
				if (stat.hist_end)
					state_n = S_RECV_COMMIT;
			end
			S_RECV_COMMIT: begin
				if (stat.hit) begin
					kind_n = K_DUPLICATE;
				end else begin
					cmd.recv_commit = 1'b1;
					kind_n = K_ACCEPTED;
				end
				state_n = S_EMIT;
			end
			S_CONF_SCAN: begin
				cmd.conf_scan = 1'b1;
				cmd.idx_inc = 1'b1;
				if (stat.slot_end)
					state_n = S_CONF_COMMIT;
			end
			S_CONF_COMMIT: begin
				cmd.use_pick = 1'b1;
				if (stat.hit) begin
					cmd.conf_commit = 1'b1;
					kind_n = K_CONFIRMED;
				end else begin
					kind_n = K_UNMATCHED;
				end
				state_n = S_EMIT;
			end
			S_TICK_SCAN: begin
				cmd.tick_scan = 1'b1;
				cmd.idx_inc = 1'b1;
				if (stat.slot_end) begin
					cmd.idx_inc = 1'b0;
					cmd.idx_clr = 1'b1;
					state_n = S_TICK_EMIT;
				end
			end
			S_TICK_EMIT: begin
				cmd.emit_kind = stat.lost_here ? K_LOST : K_RESEND;
				if (!stat.flag_here || stat.out_free) begin
					cmd.emit = stat.flag_here;
					cmd.idx_inc = 1'b1;
					if (stat.slot_end)
						state_n = S_IDLE;
				end
			end
			S_EMIT: begin
				cmd.use_pick = 1'b1;
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q <= K_SENT;
		end else begin
			state_q <= state_n;
			kind_q <= kind_n;
		end
	end

endmodule

@@ design/rmt_dp.sv @@
// rmt_dp: slot table, receive history, checksums, time and result register
// depends on rmt_pkg; commanded by rmt_ctrl

module rmt_dp import rmt_pkg::*; #(
	parameter int unsigned SEND_SLOTS    = SEND_SLOTS_DEF,
	parameter int unsigned HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_stat_t    stat,
	input  logic [7:0]  retry_limit,
	input  logic [1:0]  in_user,
	input  logic [79:0] in_data,
	input  logic        in_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] out_data,
	output logic [3:0]  out_user,
	output logic        out_last
);

	localparam int unsigned IW  = (SEND_SLOTS > 1) ? $clog2(SEND_SLOTS) : 1;
	localparam int unsigned HW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int unsigned XW  = (IW > HW) ? IW : HW;
	localparam int unsigned NW  = $clog2(SEND_SLOTS + 1);

	// latched item
	op_t         op_q;
	logic        last_q, nopay_q, rel_q, cw_q;
	logic [15:0] ival_q, tag_q, hnum_q, hchk_q, chk_q;

	logic [15:0] send_sum_q, recv_sum_q, counter_q;
	logic [31:0] time_q;

	logic [SEND_SLOTS-1:0] busy_q, flag_q, lost_q;
	logic [15:0] num_q   [SEND_SLOTS];
	logic [15:0] stag_q  [SEND_SLOTS];
	logic [15:0] sival_q [SEND_SLOTS];
	logic [7:0]  retr_q  [SEND_SLOTS];
	logic [31:0] sent_q  [SEND_SLOTS];
	logic [31:0] dl_q    [SEND_SLOTS];
	logic [NW-1:0] cnt_q;

	logic [15:0] hist_q [HISTORY_DEPTH];
	logic [HW-1:0] pos_q;

	logic [XW-1:0] idx_q;
	logic [IW-1:0] pick_q, ra;
	logic [31:0] best_q;
	logic found_q, hit_q;

	logic out_valid_q, out_last_q;
	logic [63:0] out_data_q;
	logic [3:0] out_user_q;

	logic [IW-1:0] sidx;
	logic [HW-1:0] hidx, pos_n;
	logic [7:0] r_n;
	logic [SEND_SLOTS-1:0] above;
	logic [15:0] msg, chk_o, tag_o;
	logic [IW+2:0] slot_x;
	logic [NW+3:0] cnt_x;
	logic sel_slot;

	assign sidx = idx_q[IW-1:0];
	assign hidx = idx_q[HW-1:0];
	assign ra   = cmd.use_pick ? pick_q : sidx;
	assign r_n  = (retr_q[ra] == 8'hFF) ? 8'hFF : retr_q[ra] + 8'd1;
	assign pos_n = (pos_q == HW'(HISTORY_DEPTH - 1)) ? '0 : pos_q + HW'(1);

	always_comb begin
		for (int j = 0; j < SEND_SLOTS; j++)
			above[j] = (IW'(j) > sidx);
	end

	assign stat.op        = op_q;
	assign stat.last      = last_q;
	assign stat.nopay     = nopay_q;
	assign stat.chk_ok    = (chk_q == hchk_q);
	assign stat.hit       = hit_q;
	assign stat.slot_end  = (sidx == IW'(SEND_SLOTS - 1));
	assign stat.hist_end  = (hidx == HW'(HISTORY_DEPTH - 1));
	assign stat.flag_here = flag_q[sidx];
	assign stat.lost_here = lost_q[sidx];
	assign stat.out_free  = !out_valid_q || out_ready;

	// result fields
	always_comb begin
		sel_slot = cmd.emit_kind inside {K_SENT, K_CONFIRMED, K_RESEND, K_LOST};
		case (cmd.emit_kind)
			K_SENT: msg = counter_q;
			K_RESEND, K_LOST: msg = num_q[ra];
			default: msg = hnum_q;
		endcase
		chk_o = (cmd.emit_kind <= K_DUPLICATE) ? chk_q : 16'd0;
		if (cmd.emit_kind == K_SENT)
			tag_o = tag_q;
		else if (sel_slot)
			tag_o = stag_q[ra];
		else
			tag_o = 16'd0;
		slot_x = sel_slot ? {3'd0, ra} : '0;
		cnt_x = {4'd0, cnt_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= CMD_SEND;
			last_q <= 1'b0;
			nopay_q <= 1'b0;
			rel_q <= 1'b0;
			cw_q <= 1'b0;
			ival_q <= '0;
			tag_q <= '0;
			hnum_q <= '0;
			hchk_q <= '0;
			chk_q <= '0;
			send_sum_q <= 16'd1;
			recv_sum_q <= 16'd1;
			counter_q <= 16'd1;
			time_q <= '0;
			busy_q <= '0;
			flag_q <= '0;
			lost_q <= '0;
			for (int s = 0; s < SEND_SLOTS; s++) begin
				num_q[s] <= '0;
				stag_q[s] <= '0;
				sival_q[s] <= '0;
				retr_q[s] <= '0;
				sent_q[s] <= '0;
				dl_q[s] <= '0;
			end
			cnt_q <= '0;
			pos_q <= '0;
			for (int h = 0; h < HISTORY_DEPTH; h++)
				hist_q[h] <= '0;
			idx_q <= '0;
			pick_q <= '0;
			best_q <= '0;
			found_q <= 1'b0;
			hit_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				op_q <= op_t'(in_user);
				nopay_q <= in_data[8];
				rel_q <= in_data[9];
				ival_q <= in_data[25:10];
				tag_q <= in_data[41:26];
				hnum_q <= in_data[57:42];
				hchk_q <= in_data[73:58];
				cw_q <= in_data[74];
				last_q <= in_last;
				chk_q <= sum_add((in_user == CMD_SEND) ? send_sum_q : recv_sum_q,
					in_data[7:0]);
			end
			if (cmd.sum_upd) begin
				if (op_q == CMD_SEND)
					send_sum_q <= last_q ? 16'd1 : chk_q;
				else
					recv_sum_q <= (last_q || nopay_q) ? 16'd1 : chk_q;
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
				found_q <= 1'b0;
				hit_q <= 1'b0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + XW'(1);
			end
			if (cmd.time_inc)
				time_q <= time_q + 32'd1;

			if (cmd.send_scan && !found_q) begin
				if (!busy_q[sidx]) begin
					found_q <= 1'b1;
					pick_q <= sidx;
				end else if (sidx == '0 || sent_q[sidx] < best_q) begin
					best_q <= sent_q[sidx];
					pick_q <= sidx;
				end
			end
			if (cmd.send_commit) begin
				counter_q <= (counter_q == 16'hFFFF) ? 16'd1 : counter_q + 16'd1;
				busy_q[ra] <= rel_q;
				num_q[ra] <= (counter_q == 16'hFFFF) ? 16'd1 : counter_q + 16'd1;
				stag_q[ra] <= tag_q;
				sival_q[ra] <= ival_q;
				retr_q[ra] <= '0;
				sent_q[ra] <= time_q;
				dl_q[ra] <= time_q + {16'd0, ival_q};
				if (found_q && rel_q)
					cnt_q <= cnt_q + NW'(1);
				else if (!found_q && !rel_q)
					cnt_q <= cnt_q - NW'(1);
			end

			if (cmd.recv_scan && hist_q[hidx] == hnum_q)
				hit_q <= 1'b1;
			if (cmd.recv_commit) begin
				pos_q <= pos_n;
				hist_q[pos_n] <= hnum_q;
			end

			if (cmd.conf_scan && !hit_q && busy_q[sidx] && num_q[sidx] == hnum_q) begin
				hit_q <= 1'b1;
				pick_q <= sidx;
			end
			if (cmd.conf_commit) begin
				busy_q[ra] <= 1'b0;
				cnt_q <= cnt_q - NW'(1);
			end

			if (cmd.tick_scan) begin
				flag_q[ra] <= busy_q[ra] && (dl_q[ra] < time_q);
				lost_q[ra] <= (r_n >= retry_limit);
				if (busy_q[ra] && (dl_q[ra] < time_q)) begin
					retr_q[ra] <= r_n;
					if (r_n >= retry_limit) begin
						busy_q[ra] <= 1'b0;
						cnt_q <= cnt_q - NW'(1);
					end else begin
						dl_q[ra] <= time_q + {16'd0, sival_q[ra]};
						sent_q[ra] <= time_q;
					end
				end
			end

			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_user_q <= cmd.emit_kind;
			out_last_q <= (cmd.emit_kind == K_RESEND || cmd.emit_kind == K_LOST) ?
				!(|(flag_q & above)) : 1'b1;
			out_data_q <= {6'd0, cnt_x[3:0],
				(cmd.emit_kind == K_ACCEPTED || cmd.emit_kind == K_DUPLICATE) && cw_q,
				(cmd.emit_kind == K_SENT) && !rel_q,
				(cmd.emit_kind == K_SENT) && !found_q,
				tag_o, slot_x[2:0], chk_o, msg};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_user  = out_user_q;
	assign out_last  = out_last_q;

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("result written over an untaken one");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) == 32'($countones(busy_q)))
		else $error("pending count out of step with busy slots");
	a_counter: assert property (@(posedge clk) disable iff (!arst_n)
		counter_q != 16'd0)
		else $error("message counter reached zero");
	a_commit_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.send_commit |=> !cmd.send_commit)
		else $error("send committed twice");

endmodule

@@ design/reliable_message_tracker_top.sv @@
// reliable_message_tracker_top: stream and register ports of the message tracker
// depends on rmt_pkg, rmt_ctrl and rmt_dp
//
// One transaction is taken at a time. A final send byte, a final receive byte
// that is well formed and passes its checksum, and a confirmation each run a
// scan that visits one slot or one history entry per cycle; a tick scans the
// slots once to mark expired ones and again to emit their results. A result
// that waits for the output register holds the state machine. Results leave
// through a single output register, so the next transaction may be taken while
// the last result still waits.

module reliable_message_tracker_top import rmt_pkg::*; #(
	parameter int unsigned SEND_SLOTS    = SEND_SLOTS_DEF,
	parameter int unsigned HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// data_byte[7:0], no_payload[8], reliable[9], resend_interval[25:10],
	// tag[41:26], header_number[57:42], header_check[73:58], confirm_wanted[74]
	input  logic [79:0] s_axis_tdata,
	input  logic        s_axis_tlast,
	// cmd[1:0]
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// msg_number[15:0], check_value[31:16], slot[34:32], tag_out[50:35],
	// evicted[51], auto_confirmed[52], send_confirm[53], pending_count[57:54]
	output logic [63:0] m_axis_tdata,
	output logic        m_axis_tlast,
	// kind[3:0]
	output logic [3:0]  m_axis_tuser,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	dp_cmd_t    cmd;
	dp_stat_t   stat;
	logic [7:0] retry_limit_q;

	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {24'd0, retry_limit_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_limit_q <= RETRY_LIMIT_RST;
		end else if (psel && penable && pwrite && pready && !paddr[2]) begin
			retry_limit_q <= pwdata[7:0];
		end
	end

	rmt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rmt_dp #(
		.SEND_SLOTS    (SEND_SLOTS),
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.retry_limit (retry_limit_q),
		.in_user     (s_axis_tuser),
		.in_data     (s_axis_tdata),
		.in_last     (s_axis_tlast),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_data    (m_axis_tdata),
		.out_user    (m_axis_tuser),
		.out_last    (m_axis_tlast)
	);

endmodule
